// ===== src/bitmap_page_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Shared property shorthands; every use needs clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, controller/datapath handshake structs and bit helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // map storage is organized in words of this many pages
  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = 5;

  // fixed field widths
  localparam int CNT_W   = 13;
  localparam int ADDR_W  = 32;
  localparam int PADDR_W = 3;
  localparam int REG_IDX_W = 1;

  // defaults
  localparam int DEF_MAX_PAGES  = 4096;
  localparam int DEF_PAGE_BYTES = 4096;
  localparam logic [ADDR_W-1:0] DEF_REGION_START = 32'd1048576;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_REGION_START,
    REG_PAGES_IN_USE
  } bpa_reg_t;

  typedef logic [WORD_SH:0] bpa_wcnt_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic decide;
    logic scan_start;
    logic scan;
    logic mod_start;
    logic modify;
    logic clear;
    logic result;
  } bpa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_free;
    logic alloc_ok;
    logic free_do_mod;
    logic scan_hit;
    logic scan_last;
    logic mod_last;
    logic clr_last;
  } bpa_status_t;

  // number of consecutive ones starting at bit 0
  function automatic bpa_wcnt_t trail_ones(input logic [WORD_BITS-1:0] v);
    bpa_wcnt_t n;
    n = bpa_wcnt_t'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) n = bpa_wcnt_t'(i);
    end
    return n;
  endfunction

  // number of consecutive ones ending at the top bit
  function automatic bpa_wcnt_t lead_ones(input logic [WORD_BITS-1:0] v);
    bpa_wcnt_t n;
    n = bpa_wcnt_t'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!v[i]) n = bpa_wcnt_t'(WORD_BITS - 1 - i);
    end
    return n;
  endfunction

  // index of the lowest set bit (0 when none)
  function automatic logic [WORD_SH-1:0] low_index(input logic [WORD_BITS-1:0] v);
    logic [WORD_SH-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) n = WORD_SH'(i);
    end
    return n;
  endfunction

endpackage

// ===== src/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences clearing, decision, map scan, map update and result hand-off.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_top_assert.svh"

module bpa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bpa_pkg::bpa_status_t st,
  output bpa_pkg::bpa_cmd_t    cmd
);

  import bpa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN_START,
    S_SCAN,
    S_MOD_START,
    S_MOD,
    S_FINISH
  } state_t;

  state_t state, state_next;

  // requests are taken only between operations
  assign in_stall = (state != S_IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (st.op_free) begin
          state_next = st.free_do_mod ? S_MOD_START : S_FINISH;
        end else begin
          state_next = st.alloc_ok ? S_SCAN_START : S_FINISH;
        end
      end
      S_SCAN_START: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_hit) state_next = S_MOD_START;
        else if (st.scan_last) state_next = S_FINISH;
      end
      S_MOD_START: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MOD;
      end
      S_MOD: begin
        cmd.modify = 1'b1;
        if (st.mod_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        // wait for the output register to free up
        cmd.result = !out_valid || !out_stall;
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `BPA_ASSERT_IMP(a_result_slot_free, cmd.result, (!out_valid || !out_stall), "result overwrote pending output")
  `BPA_ASSERT_IMP(a_out_from_finish, $rose(out_valid), $past(state == S_FINISH), "output valid raised outside finish")
  `BPA_ASSERT_NXT(a_out_held, (out_valid && out_stall), out_valid, "stalled output dropped")

endmodule

// ===== src/bpa_dp.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Request registers, first-fit word scanner, range update and result regs.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_top_assert.svh"

module bpa_dp #(
  parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES,
  parameter int WIDX_W     = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bpa_pkg::bpa_cmd_t            cmd,
  output bpa_pkg::bpa_status_t         st,
  input  logic                         func,
  input  logic [bpa_pkg::CNT_W-1:0]    req_pages,
  input  logic [bpa_pkg::ADDR_W-1:0]   free_addr,
  input  logic [bpa_pkg::ADDR_W-1:0]   region_start,
  input  logic [bpa_pkg::CNT_W-1:0]    pages_in_use,
  output logic                         ram_we,
  output logic [WIDX_W-1:0]            ram_waddr,
  output logic [bpa_pkg::WORD_BITS-1:0] ram_wdata,
  output logic [WIDX_W-1:0]            ram_raddr,
  input  logic [bpa_pkg::WORD_BITS-1:0] ram_rdata,
  output logic [bpa_pkg::ADDR_W-1:0]   alloc_addr,
  output logic                         granted
);

  import bpa_pkg::*;

  localparam int MEM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int PIDX_W    = $clog2(MAX_PAGES + 1);
  localparam int PB_SHIFT  = $clog2(PAGE_BYTES);

  // request and operation registers
  logic                 op_free;
  logic [CNT_W-1:0]     cnt;
  logic [ADDR_W-1:0]    offset;
  logic [PIDX_W-1:0]    limit;
  logic [PIDX_W-1:0]    lo;
  logic [PIDX_W-1:0]    hi;
  logic [WIDX_W-1:0]    last_word;
  logic [WORD_BITS-1:0] tail_mask;
  logic [CNT_W-1:0]     carry;
  logic [PIDX_W-1:0]    run_start;
  logic                 grant;
  logic [WIDX_W-1:0]    widx;

  // decision terms
  logic [ADDR_W-1:0]    lim32;
  logic [ADDR_W-1:0]    first32;
  logic [ADDR_W-1:0]    end32;
  logic [ADDR_W-1:0]    hi32;
  logic [WORD_SH-1:0]   lim_off;

  always_comb begin
    lim32   = (ADDR_W'(pages_in_use) < ADDR_W'(MAX_PAGES)) ?
              ADDR_W'(pages_in_use) : ADDR_W'(MAX_PAGES);
    first32 = offset >> PB_SHIFT;
    end32   = first32 + ADDR_W'(cnt);
    hi32    = (end32 < lim32) ? end32 : lim32;
    lim_off = lim32[WORD_SH-1:0];
  end

  // scan of one map word
  logic [PIDX_W-1:0]    wpos;
  logic [WORD_BITS-1:0] used;
  logic [WORD_BITS-1:0] freew;
  bpa_wcnt_t            tz;
  bpa_wcnt_t            lz;
  logic [PIDX_W-1:0]    start_eff;
  logic [CNT_W:0]       carry_sum;
  logic                 carry_hit;
  logic [WORD_BITS-1:0] endw [WORD_SH];
  logic [WORD_BITS-1:0] rwin;
  logic                 in_hit;
  logic [WORD_SH-1:0]   in_end;
  logic [PIDX_W-1:0]    base_in;
  logic [PIDX_W-1:0]    base;
  logic [PIDX_W-1:0]    hi_hit;

  always_comb begin
    wpos      = PIDX_W'({widx, {WORD_SH{1'b0}}});
    used      = ram_rdata | ((widx == last_word) ? tail_mask : '0);
    freew     = ~used;
    tz        = trail_ones(freew);
    lz        = lead_ones(freew);
    start_eff = (carry == '0) ? wpos : run_start;
    carry_sum = {1'b0, carry} + (CNT_W + 1)'(tz);
    carry_hit = carry_sum >= {1'b0, cnt};
    // free windows of power-of-two length, marked at their last bit
    endw[0] = freew;
    for (int k = 1; k < WORD_SH; k++) begin
      endw[k] = endw[k-1] & (endw[k-1] << (1 << (k - 1)));
    end
    // compose a window of exactly cnt free pages inside the word
    rwin = '1;
    for (int k = 0; k < WORD_SH; k++) begin
      if (cnt[k]) rwin = endw[k] & (rwin << (1 << k));
    end
    if (cnt[CNT_W-1:WORD_SH] != '0) rwin = '0;
    in_hit  = |rwin;
    in_end  = low_index(rwin);
    base_in = wpos + PIDX_W'(in_end) + PIDX_W'(1) - PIDX_W'(cnt);
    base    = carry_hit ? start_eff : base_in;
    hi_hit  = base + PIDX_W'(cnt);
  end

  // range update of one map word
  logic [WIDX_W-1:0]    lo_w;
  logic [WIDX_W-1:0]    hi_last;
  logic [WORD_SH-1:0]   lo_off;
  logic [WORD_SH-1:0]   hi_off;
  logic [PIDX_W-1:0]    hi_m1;
  logic [WORD_BITS-1:0] mod_mask;
  logic [WORD_BITS-1:0] mod_word;

  always_comb begin
    hi_m1    = hi - PIDX_W'(1);
    lo_w     = WIDX_W'(lo >> WORD_SH);
    hi_last  = WIDX_W'(hi_m1 >> WORD_SH);
    lo_off   = WORD_SH'(lo);
    hi_off   = WORD_SH'(hi_m1);
    mod_mask = ((widx == lo_w) ? ({WORD_BITS{1'b1}} << lo_off) : {WORD_BITS{1'b1}}) &
               ((widx == hi_last) ?
                ({WORD_BITS{1'b1}} >> (WORD_SH'(WORD_BITS - 1) - hi_off)) :
                {WORD_BITS{1'b1}});
    mod_word = op_free ? (ram_rdata & ~mod_mask) : (ram_rdata | mod_mask);
  end

  // status to controller
  always_comb begin
    st.op_free     = op_free;
    st.alloc_ok    = (cnt != '0) && (ADDR_W'(cnt) <= lim32);
    st.free_do_mod = first32 < hi32;
    st.scan_hit    = carry_hit || in_hit;
    st.scan_last   = (widx == last_word);
    st.mod_last    = (widx == hi_last);
    st.clr_last    = (widx == WIDX_W'(MEM_WORDS - 1));
  end

  // map memory access
  always_comb begin
    ram_we    = cmd.modify || cmd.clear;
    ram_waddr = widx;
    ram_wdata = cmd.clear ? '0 : mod_word;
    if (cmd.scan_start) ram_raddr = '0;
    else if (cmd.mod_start) ram_raddr = lo_w;
    else ram_raddr = widx + WIDX_W'(1);
  end

  // word index walks the clear pass, the scan and the update
  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
    end else begin
      if (cmd.clear || cmd.modify) widx <= widx + WIDX_W'(1);
      else if (cmd.scan_start) widx <= '0;
      else if (cmd.mod_start) widx <= lo_w;
      else if (cmd.scan && !(carry_hit || in_hit)) widx <= widx + WIDX_W'(1);
    end
  end

  // operation registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_free <= func;
      cnt     <= req_pages;
      offset  <= free_addr - region_start;
    end
    if (cmd.decide) begin
      limit     <= PIDX_W'(lim32);
      last_word <= WIDX_W'((lim32 - ADDR_W'(1)) >> WORD_SH);
      tail_mask <= (lim_off == '0) ? '0 : ({WORD_BITS{1'b1}} << lim_off);
      lo        <= PIDX_W'(first32);
      hi        <= PIDX_W'(hi32);
      grant     <= (op_free == FUNC_FREE);
    end
    if (cmd.scan_start) begin
      carry <= '0;
    end
    if (cmd.scan) begin
      if (carry_hit || in_hit) begin
        lo    <= base;
        hi    <= hi_hit;
        grant <= 1'b1;
      end else if (tz == bpa_wcnt_t'(WORD_BITS)) begin
        carry     <= CNT_W'(carry_sum);
        run_start <= start_eff;
      end else begin
        carry     <= CNT_W'(lz);
        run_start <= wpos + PIDX_W'(WORD_BITS) - PIDX_W'(lz);
      end
    end
    if (cmd.result) begin
      granted    <= grant;
      alloc_addr <= (grant && (op_free == FUNC_ALLOC)) ?
                    region_start + (ADDR_W'(lo) << PB_SHIFT) : '0;
    end
  end

  `BPA_ASSERT_IMP(a_mod_in_range, cmd.modify, (widx >= lo_w && widx <= hi_last), "update outside range")
  `BPA_ASSERT_IMP(a_hit_in_region, (cmd.scan && (carry_hit || in_hit)), (hi_hit <= limit), "run beyond region")
  `BPA_ASSERT_NXT(a_free_result, (cmd.result && op_free == FUNC_FREE), (granted && alloc_addr == '0), "bad free result")

endmodule

// ===== src/bitmap_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator, top level
// First-fit allocator of contiguous pages over a one-bit-per-page map.
//
//   channel  direction  handshake              payload
//   in       request    in_valid / in_stall    func, req_pages, free_addr
//   out      response   out_valid / out_stall  alloc_addr, granted
//   config   APB write  psel/penable/pwrite    region_start @0, pages_in_use @4
//
// An allocation scans the 32-page map words first-fit (up to ceil(region/32)
// words, 128 by default), then updates the map words of the run it found; a
// free updates its map words directly. A request rejected at the decision
// step skips both, and a failed scan updates nothing. Requests wait for idle.
// After reset a clearing pass writes ceil(MAX_PAGES/32) words (128 by
// default) while in_stall stays high; config writes are taken throughout.
// A finished response sits in the output register; the next request is
// accepted meanwhile and completes once that register has been taken.
// PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top #(
  parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [bpa_pkg::CNT_W-1:0]     req_pages,
  input  logic [bpa_pkg::ADDR_W-1:0]    free_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpa_pkg::ADDR_W-1:0]    alloc_addr,
  output logic                          granted,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import bpa_pkg::*;

  localparam int MEM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [ADDR_W-1:0] region_start;
  logic [CNT_W-1:0]  pages_in_use;
  bpa_reg_t          reg_idx;

  bpa_cmd_t          cmd;
  bpa_status_t       st;

  logic                 ram_we;
  logic [WIDX_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WIDX_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // register port: zero wait states
  assign pready  = 1'b1;
  assign reg_idx = bpa_reg_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= DEF_REGION_START;
      pages_in_use <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_REGION_START: region_start <= pwdata;
        REG_PAGES_IN_USE: pages_in_use <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_REGION_START: prdata = region_start;
      REG_PAGES_IN_USE: prdata = 32'(pages_in_use);
      default:          prdata = '0;
    endcase
  end

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  bpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .WIDX_W     (WIDX_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .func         (func),
    .req_pages    (req_pages),
    .free_addr    (free_addr),
    .region_start (region_start),
    .pages_in_use (pages_in_use),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .alloc_addr   (alloc_addr),
    .granted      (granted)
  );

  // page occupancy map, one word per 32 pages
  bpa_ram #(
    .WIDTH  (WORD_BITS),
    .DEPTH  (MEM_WORDS),
    .ADDR_W (WIDX_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
